// File: sv/tms3_pkg.sv
// Package for the 3-D trapezoidal motion step block.
// Holds constants, datapath op codes and the controller/datapath structs.
// No dependencies.
`default_nettype none
package tms3_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int FLD_W        = 24;
  localparam int SPD_W        = 13;
  localparam int ACC_W        = 16;
  localparam int DT_W         = 16;
  localparam int MUL_W        = 32;
  localparam int SQ_W         = 64;
  localparam int CNT_W        = 6;

  localparam int HOME_X    = 96000;
  localparam int HOME_Y    = 0;
  localparam int HOME_Z    = 30400;
  localparam int VGAP      = 16;
  localparam int ARRIVE_SQ = 2;

  localparam logic [ACC_W-1:0] ACCEL_RST  = 16'd3200;
  localparam logic [SPD_W-1:0] TRAVEL_RST = 13'd6400;
  localparam logic [SPD_W-1:0] HOIST_RST  = 13'd4000;

  localparam logic [1:0] CFG_ACCEL  = 2'd0;
  localparam logic [1:0] CFG_TRAVEL = 2'd1;
  localparam logic [1:0] CFG_HOIST  = 2'd2;

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP   = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_HOME  = 5'd2;
  localparam op_t OP_DIFF  = 5'd3;
  localparam op_t OP_SQ    = 5'd4;
  localparam op_t OP_RINIT = 5'd5;
  localparam op_t OP_RITER = 5'd6;
  localparam op_t OP_DIST  = 5'd7;
  localparam op_t OP_MULW  = 5'd8;
  localparam op_t OP_WANT  = 5'd9;
  localparam op_t OP_STEP  = 5'd10;
  localparam op_t OP_SPEED = 5'd11;
  localparam op_t OP_MOVE  = 5'd12;
  localparam op_t OP_SNAP  = 5'd13;
  localparam op_t OP_DINIT = 5'd14;
  localparam op_t OP_DITER = 5'd15;
  localparam op_t OP_APPLY = 5'd16;
  localparam op_t OP_ARR   = 5'd17;
  localparam op_t OP_OUT   = 5'd18;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic snap;
    logic move_zero;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/trapezoid_motion_step_3d.sv
// Top level of the 3-D trapezoidal motion step block.
// Joins tms3_ctrl and tms3_dp; uses tms3_pkg.
//
//  channel | signals                                   | accepted when
//  in      | in_valid/in_ready, action, target, step   | in_valid & in_ready
//  out     | out_valid/out_ready, pos, speed, arrived  | out_valid & out_ready
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | cfg_valid (ready tied high)
//
// A motion request runs two 32-step square roots and, when the position
// moves partly, one 37-step restoring division per axis, with a single
// shared multiplier. A home request goes from idle straight to the final
// state. Reset is synchronous, active low.
// A result waiting on out_ready holds only the final state; the next request
// is taken meanwhile.
`default_nettype none
module trapezoid_motion_step_3d import tms3_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_action,
  input  wire logic signed [FLD_W-1:0] in_target_x,
  input  wire logic signed [FLD_W-1:0] in_target_y,
  input  wire logic signed [FLD_W-1:0] in_target_z,
  input  wire logic [DT_W-1:0]         in_time_step,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [FLD_W-1:0]      out_pos_x,
  output logic signed [FLD_W-1:0]      out_pos_y,
  output logic signed [FLD_W-1:0]      out_pos_z,
  output logic [SPD_W-1:0]             out_cur_speed,
  output logic                         out_arrived,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [ACC_W-1:0]        cfg_data
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tms3_ctrl #(.POS_BITS(POS_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tms3_dp #(.POS_BITS(POS_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .in_target_z   (in_target_z),
    .in_time_step  (in_time_step),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_cur_speed (out_cur_speed),
    .out_arrived   (out_arrived)
  );
endmodule
`default_nettype wire

// File: sv/tms3_ctrl.sv
// Sequencer for the motion step: walks the datapath through distance,
// square roots, speed update, per-axis division and arrival check. Uses tms3_pkg.
`default_nettype none
module tms3_ctrl import tms3_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_action,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  stat_t     stat
);
  localparam int DW = ((POS_BITS > FLD_W) ? POS_BITS : FLD_W) + 1;
  localparam int NW = DW - 1 + SPD_W;
  localparam logic [CNT_W-1:0] RLAST = CNT_W'(SQ_W / 2 - 1);
  localparam logic [CNT_W-1:0] DLAST = CNT_W'(NW - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_RINIT = 4'd3;
  localparam logic [3:0] S_RITER = 4'd4;
  localparam logic [3:0] S_RDONE = 4'd5;
  localparam logic [3:0] S_MULW  = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_SPEED = 4'd8;
  localparam logic [3:0] S_MOVE  = 4'd9;
  localparam logic [3:0] S_BR    = 4'd10;
  localparam logic [3:0] S_DINIT = 4'd11;
  localparam logic [3:0] S_DITER = 4'd12;
  localparam logic [3:0] S_APPLY = 4'd13;
  localparam logic [3:0] S_ARR   = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic             pass_r, pass_nxt;
  logic             root_r, root_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    pass_nxt      = pass_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NOP;
    cmd.axis      = axis_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = in_action ? OP_HOME : OP_LOAD;
          state_nxt = in_action ? S_FIN : S_DIFF;
          pass_nxt  = 1'b0;
          root_nxt  = 1'b0;
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        axis_nxt  = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (axis_r == 2'd2) begin
          state_nxt = pass_r ? S_ARR : S_RINIT;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_RINIT: begin
        cmd.op    = OP_RINIT;
        cnt_nxt   = '0;
        state_nxt = S_RITER;
      end
      S_RITER: begin
        cmd.op  = OP_RITER;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RLAST) state_nxt = S_RDONE;
      end
      S_RDONE: begin
        cmd.op    = root_r ? OP_WANT : OP_DIST;
        state_nxt = root_r ? S_STEP : S_MULW;
      end
      S_MULW: begin
        cmd.op    = OP_MULW;
        root_nxt  = 1'b1;
        state_nxt = S_RINIT;
      end
      S_STEP: begin
        cmd.op    = OP_STEP;
        state_nxt = S_SPEED;
      end
      S_SPEED: begin
        cmd.op    = OP_SPEED;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.op    = OP_MOVE;
        state_nxt = S_BR;
      end
      S_BR: begin
        pass_nxt = 1'b1;
        axis_nxt = 2'd0;
        priority if (stat.snap) begin
          cmd.op    = OP_SNAP;
          state_nxt = S_DIFF;
        end else if (stat.move_zero) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.op    = OP_DINIT;
        cnt_nxt   = '0;
        state_nxt = S_DITER;
      end
      S_DITER: begin
        cmd.op  = OP_DITER;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DLAST) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.op = OP_APPLY;
        if (axis_r == 2'd2) begin
          state_nxt = S_DIFF;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DINIT;
        end
      end
      S_ARR: begin
        cmd.op    = OP_ARR;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      axis_r      <= '0;
      pass_r      <= 1'b0;
      root_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      axis_r      <= axis_nxt;
      pass_r      <= pass_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: sv/tms3_dp.sv
// Datapath for the motion step: position, speed and config registers, a shared
// multiplier, a bit-serial square root and a restoring divider. Uses tms3_pkg.
`default_nettype none
module tms3_dp import tms3_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  wire logic                    cfg_valid,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [ACC_W-1:0]        cfg_data,
  input  wire logic signed [FLD_W-1:0] in_target_x,
  input  wire logic signed [FLD_W-1:0] in_target_y,
  input  wire logic signed [FLD_W-1:0] in_target_z,
  input  wire logic [DT_W-1:0]         in_time_step,
  output logic signed [FLD_W-1:0]      out_pos_x,
  output logic signed [FLD_W-1:0]      out_pos_y,
  output logic signed [FLD_W-1:0]      out_pos_z,
  output logic [SPD_W-1:0]             out_cur_speed,
  output logic                         out_arrived
);
  localparam int P  = POS_BITS;
  localparam int DW = ((P > FLD_W) ? P : FLD_W) + 1;
  localparam int MW = DW - 1;
  localparam int NW = MW + SPD_W;
  localparam int SW = NW + 2;
  localparam logic signed [SW-1:0] PMAX = SW'({1'b0, {(P-1){1'b1}}});
  localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);
  localparam logic signed [SW-1:0] HX = SW'(HOME_X);
  localparam logic signed [SW-1:0] HY = SW'(HOME_Y);
  localparam logic signed [SW-1:0] HZ = SW'(HOME_Z);

  function automatic logic signed [P-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v;
    if (v > PMAX) t = PMAX;
    if (v < PMIN) t = PMIN;
    return t[P-1:0];
  endfunction

  logic [ACC_W-1:0]        accel_r;
  logic [SPD_W-1:0]        travel_r, hoist_r;
  logic signed [P-1:0]     pos_r [3];
  logic signed [FLD_W-1:0] tgt_r [3];
  logic signed [DW-1:0]    d_r [3];
  logic [DT_W-1:0]         dt_r;
  logic [SPD_W-1:0]        speed_r, wanted_r, move_r;
  logic [ACC_W-1:0]        step_r;
  logic [SQ_W-1:0]         acc_r, v_r, r_r, bit_r;
  logic [MUL_W-1:0]        dist_r, rem_r;
  logic [NW-1:0]           dvd_r;
  logic                    arr_r;

  logic signed [DW-1:0]    d_sel;
  logic [MW-1:0]           mag;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [2*MUL_W-1:0]      prod;
  logic [SQ_W-1:0]         r_bit;
  logic [MUL_W:0]          rem_sh;
  logic signed [SW-1:0]    q_ext, p_ext, p_new;
  logic [SPD_W-1:0]        limit;
  logic [SPD_W:0]          up_sum;

  assign d_sel  = d_r[cmd.axis];
  assign mag    = d_sel[DW-1] ? MW'(-d_sel) : MW'(d_sel);
  assign prod   = mul_a * mul_b;
  assign r_bit  = r_r + bit_r;
  assign rem_sh = {rem_r, dvd_r[NW-1]};
  assign q_ext  = SW'({1'b0, dvd_r});
  assign p_ext  = SW'(pos_r[cmd.axis]);
  assign p_new  = d_sel[DW-1] ? (p_ext - q_ext) : (p_ext + q_ext);
  assign limit  = ((d_r[2] > DW'(VGAP)) || (d_r[2] < -DW'(VGAP))) ? hoist_r : travel_r;
  assign up_sum = {1'b0, speed_r} + (SPD_W+1)'(step_r);

  assign stat.snap      = (MUL_W'(move_r) >= dist_r);
  assign stat.move_zero = (move_r == '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ:    begin mul_a = MUL_W'(mag);     mul_b = MUL_W'(mag);     end
      OP_MULW:  begin mul_a = MUL_W'(accel_r); mul_b = dist_r;          end
      OP_STEP:  begin mul_a = MUL_W'(accel_r); mul_b = MUL_W'(dt_r);    end
      OP_MOVE:  begin mul_a = MUL_W'(speed_r); mul_b = MUL_W'(dt_r);    end
      OP_DINIT: begin mul_a = MUL_W'(mag);     mul_b = MUL_W'(move_r);  end
      default:  begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r  <= ACCEL_RST;
      travel_r <= TRAVEL_RST;
      hoist_r  <= HOIST_RST;
      pos_r[0] <= sat(HX);
      pos_r[1] <= sat(HY);
      pos_r[2] <= sat(HZ);
      speed_r  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ACCEL:  accel_r  <= cfg_data;
          CFG_TRAVEL: travel_r <= cfg_data[SPD_W-1:0];
          CFG_HOIST:  hoist_r  <= cfg_data[SPD_W-1:0];
          default:    ;
        endcase
      end
      unique case (cmd.op)
        OP_HOME: begin
          pos_r[0] <= sat(HX);
          pos_r[1] <= sat(HY);
          pos_r[2] <= sat(HZ);
          speed_r  <= '0;
        end
        OP_SPEED: begin
          if (wanted_r > speed_r) begin
            speed_r <= (ACC_W'(wanted_r - speed_r) <= step_r) ?
                       wanted_r : up_sum[SPD_W-1:0];
          end else begin
            speed_r <= ((ACC_W+1)'(speed_r - wanted_r) <= (ACC_W+1)'(step_r)) ?
                       wanted_r : (speed_r - SPD_W'(step_r));
          end
        end
        OP_SNAP: begin
          pos_r[0] <= sat(SW'(tgt_r[0]));
          pos_r[1] <= sat(SW'(tgt_r[1]));
          pos_r[2] <= sat(SW'(tgt_r[2]));
        end
        OP_APPLY: pos_r[cmd.axis] <= sat(p_new);
        OP_ARR:   if (acc_r <= SQ_W'(ARRIVE_SQ)) speed_r <= '0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        tgt_r[0] <= in_target_x;
        tgt_r[1] <= in_target_y;
        tgt_r[2] <= in_target_z;
        dt_r     <= in_time_step;
      end
      OP_HOME: arr_r <= 1'b0;
      OP_DIFF: begin
        d_r[0] <= DW'(tgt_r[0]) - DW'(pos_r[0]);
        d_r[1] <= DW'(tgt_r[1]) - DW'(pos_r[1]);
        d_r[2] <= DW'(tgt_r[2]) - DW'(pos_r[2]);
        acc_r  <= '0;
      end
      OP_SQ:    acc_r <= acc_r + prod;
      OP_RINIT: begin
        v_r   <= acc_r;
        r_r   <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
      end
      OP_RITER: begin
        if (v_r >= r_bit) begin
          v_r <= v_r - r_bit;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIST:  dist_r <= r_r[MUL_W-1:0];
      OP_MULW:  acc_r <= {prod[2*MUL_W-2:0], 1'b0};
      OP_WANT:  wanted_r <= (r_r > SQ_W'(limit)) ? limit : r_r[SPD_W-1:0];
      OP_STEP:  step_r <= prod[DT_W +: ACC_W];
      OP_MOVE:  move_r <= prod[DT_W +: SPD_W];
      OP_DINIT: begin
        dvd_r <= prod[NW-1:0];
        rem_r <= '0;
      end
      OP_DITER: begin
        if (rem_sh >= {1'b0, dist_r}) begin
          rem_r <= MUL_W'(rem_sh - {1'b0, dist_r});
          dvd_r <= {dvd_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[MUL_W-1:0];
          dvd_r <= {dvd_r[NW-2:0], 1'b0};
        end
      end
      OP_ARR:   arr_r <= (acc_r <= SQ_W'(ARRIVE_SQ));
      OP_OUT: begin
        out_pos_x     <= FLD_W'(SW'(pos_r[0]));
        out_pos_y     <= FLD_W'(SW'(pos_r[1]));
        out_pos_z     <= FLD_W'(SW'(pos_r[2]));
        out_cur_speed <= speed_r;
        out_arrived   <= arr_r;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for trapezoid_motion_step_3d: directed table, then random motion runs.
// Predicts results with its own motion model or the table; checks fields in order.
// Depends on tms3_pkg and the RTL of the block.
module tb_top;
  import tms3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 6000;
  localparam int HOLD_CYC   = 1500;
  localparam int DRAIN_CYC  = 300;

  typedef struct {
    bit                    act;
    logic signed [23:0]    tx, ty, tz;
    logic [DT_W-1:0]       dt;
  } motion_req_t;

  typedef struct {
    logic signed [23:0]    px, py, pz;
    logic [SPD_W-1:0]      spd;
    bit                    arr;
  } motion_res_t;

  typedef struct {
    motion_req_t req;
    bit          known;
    motion_res_t res;
  } table_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_action = 0;
  logic signed [FLD_W-1:0] in_target_x = 0, in_target_y = 0, in_target_z = 0;
  logic [DT_W-1:0] in_time_step = 0;
  logic out_ready = 0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = CFG_ACCEL;
  logic [ACC_W-1:0] cfg_data = 0;
  wire in_ready, out_valid, out_arrived, cfg_ready;
  wire signed [FLD_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  wire [SPD_W-1:0] out_cur_speed;

  trapezoid_motion_step_3d dut (.*);

  initial forever #5 clk = ~clk;

  longint mx, my, mz;
  longint unsigned mspd, macc, mtrv, mhst;
  motion_res_t pending_pos[$];
  int errors = 0, res_cnt = 0, arr_cnt = 0, sent = 0;
  int idle_mode = 0;
  bit hold_done = 0;
  int quiet = 0;

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag2(input longint d);
    longint unsigned a = d < 0 ? -d : d;
    return a * a;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 8388607;
    if (v < -64'sd8388608) return -8388608;
    return v;
  endfunction

  function automatic longint share(input longint d, input longint unsigned mv,
                                   input longint unsigned den);
    longint unsigned a = d < 0 ? -d : d;
    longint unsigned q = a * mv / den;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic motion_res_t next_position(input motion_req_t r);
    motion_res_t e;
    longint tx, ty, tz, dx, dy, dz;
    longint unsigned dlen, lim, want, stp, mv;
    if (r.act) begin
      mx = HOME_X; my = HOME_Y; mz = HOME_Z; mspd = 0;
      e.arr = 0;
    end else begin
      tx = r.tx; ty = r.ty; tz = r.tz;
      dx = tx - mx; dy = ty - my; dz = tz - mz;
      dlen = isqrt(mag2(dx) + mag2(dy) + mag2(dz));
      lim = (dz > VGAP || dz < -VGAP) ? mhst : mtrv;
      want = isqrt(2 * macc * dlen);
      if (want > lim) want = lim;
      stp = (macc * r.dt) >> 16;
      if (want > mspd) mspd = (want - mspd <= stp) ? want : mspd + stp;
      else mspd = (mspd - want <= stp) ? want : mspd - stp;
      mv = (mspd * r.dt) >> 16;
      if (dlen <= mv) begin
        mx = clamp24(tx); my = clamp24(ty); mz = clamp24(tz);
      end else if (mv != 0) begin
        mx = clamp24(mx + share(dx, mv, dlen));
        my = clamp24(my + share(dy, mv, dlen));
        mz = clamp24(mz + share(dz, mv, dlen));
      end
      e.arr = (mag2(tx - mx) + mag2(ty - my) + mag2(tz - mz)) <= ARRIVE_SQ;
      if (e.arr) mspd = 0;
    end
    e.px = mx[23:0]; e.py = my[23:0]; e.pz = mz[23:0]; e.spd = mspd[12:0];
    return e;
  endfunction

  task automatic send_request(input motion_req_t r, input bit known, input motion_res_t kr);
    motion_res_t e;
    int gap = 0;
    if (idle_mode == 0 && $urandom_range(99) < 10) gap = $urandom_range(1, 3);
    if (idle_mode == 1 && $urandom_range(99) < 62) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= r.act;
    in_target_x <= r.tx;
    in_target_y <= r.ty;
    in_target_z <= r.tz;
    in_time_step <= r.dt;
    do @(posedge clk); while (!in_ready);
    e = next_position(r);
    pending_pos.push_back(known ? kr : e);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ACC_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_ACCEL:  macc = val;
      CFG_TRAVEL: mtrv = val[SPD_W-1:0];
      CFG_HOIST:  mhst = val[SPD_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    motion_res_t x;
    if (out_valid && out_ready) begin
      res_cnt++;
      if (out_arrived) arr_cnt++;
      if (pending_pos.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        x = pending_pos.pop_front();
        if (out_pos_x !== x.px) begin
          $error("pos_x exp %0d got %0d", x.px, out_pos_x); errors++;
        end
        if (out_pos_y !== x.py) begin
          $error("pos_y exp %0d got %0d", x.py, out_pos_y); errors++;
        end
        if (out_pos_z !== x.pz) begin
          $error("pos_z exp %0d got %0d", x.pz, out_pos_z); errors++;
        end
        if (out_cur_speed !== x.spd) begin
          $error("cur_speed exp %0d got %0d", x.spd, out_cur_speed); errors++;
        end
        if (out_arrived !== x.arr) begin
          $error("arrived exp %0d got %0d", x.arr, out_arrived); errors++;
        end
      end
    end
  end

  // receiver: random stalls by mode, one long hold-off to back up the input
  initial begin
    out_ready <= 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && res_cnt >= 400) begin
        hold_done = 1;
        out_ready <= 0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      case (idle_mode)
        0: out_ready <= ($urandom_range(99) >= 62);
        1: out_ready <= ($urandom_range(99) >= 10);
        default: out_ready <= 1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic motion_req_t mk(bit a, int x, int y, int z, int t);
    motion_req_t r;
    r.act = a; r.tx = 24'(x); r.ty = 24'(y); r.tz = 24'(z); r.dt = 16'(t);
    return r;
  endfunction

  function automatic motion_res_t at(int x, int y, int z, int s, bit a);
    motion_res_t e;
    e.px = 24'(x); e.py = 24'(y); e.pz = 24'(z); e.spd = 13'(s); e.arr = a;
    return e;
  endfunction

  initial begin
    table_row_t rows[$];
    motion_req_t r;
    motion_res_t none;
    int unsigned acc_v[6] = '{3200, 65535, 0, 1, 0, 3200};
    int unsigned trv_v[6] = '{6400, 8191, 0, 1, 0, 6400};
    int unsigned hst_v[6] = '{4000, 8191, 0, 8191, 0, 4000};
    int unsigned span;
    int steps;
    longint tgx, tgy, tgz;
    none = at(0, 0, 0, 0, 0);
    macc = ACCEL_RST; mtrv = TRAVEL_RST; mhst = HOIST_RST;
    mx = HOME_X; my = HOME_Y; mz = HOME_Z; mspd = 0;

    rows.push_back('{mk(0, 96000, 0, 30400, 0), 1, at(96000, 0, 30400, 0, 1)});
    rows.push_back('{mk(0, 0, 0, 0, 0), 1, at(96000, 0, 30400, 0, 0)});
    rows.push_back('{mk(0, 96001, 0, 30400, 0), 1, at(96000, 0, 30400, 0, 1)});
    rows.push_back('{mk(0, 96001, 0, 30401, 0), 1, at(96000, 0, 30400, 0, 1)});
    rows.push_back('{mk(0, 96001, 1, 30401, 0), 1, at(96000, 0, 30400, 0, 0)});
    rows.push_back('{mk(1, -1, -1, -1, 65535), 1, at(96000, 0, 30400, 0, 0)});
    rows.push_back('{mk(0, 96000, 0, 30416, 4000), 0, none});
    rows.push_back('{mk(0, 96000, 0, 30433, 4000), 0, none});
    rows.push_back('{mk(0, 100000, 3000, 30400, 9000), 0, none});
    rows.push_back('{mk(0, 100000, 3000, 30400, 30000), 0, none});
    rows.push_back('{mk(0, 100000, 3000, 30400, 65535), 0, none});
    rows.push_back('{mk(0, 8388607, 8388607, 8388607, 65535), 0, none});
    rows.push_back('{mk(0, 8388607, 8388607, 8388607, 65535), 0, none});
    rows.push_back('{mk(0, -8388608, -8388608, -8388608, 65535), 0, none});
    rows.push_back('{mk(0, 96100, -50, 30000, 1), 0, none});
    rows.push_back('{mk(1, 8388607, -8388608, 0, 0), 1, at(96000, 0, 30400, 0, 0)});
    rows.push_back('{mk(0, 95000, 200, 31000, 20000), 0, none});
    rows.push_back('{mk(0, 95000, 200, 31000, 0), 0, none});

    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph / 2;
      drain();
      if (ph > 0) begin
        write_reg(CFG_ACCEL, 16'(ph == 4 ? $urandom_range(65535) : acc_v[ph]));
        write_reg(CFG_TRAVEL, {3'($urandom_range(7)),
                  13'(ph == 4 ? $urandom_range(8191) : trv_v[ph])});
        write_reg(CFG_HOIST, {3'($urandom_range(7)),
                  13'(ph == 4 ? $urandom_range(8191) : hst_v[ph])});
      end
      for (int n = 0; n < 290; ) begin
        if ($urandom_range(99) < 15) begin
          r.act = $urandom_range(99) < 30;
          r.tx = 24'($urandom); r.ty = 24'($urandom); r.tz = 24'($urandom);
          r.dt = 16'($urandom);
          send_request(r, 0, none);
          n++;
        end else begin
          span = $urandom_range(3) == 0 ? 40 : $urandom_range(8000);
          tgx = mx + $signed($urandom_range(2 * span)) - span;
          tgy = my + $signed($urandom_range(2 * span)) - span;
          tgz = mz + ($urandom_range(1) ? $signed($urandom_range(2 * span)) - span
                                         : $signed($urandom_range(32)) - 16);
          steps = $urandom_range(4, 30);
          for (int k = 0; k < steps; k++) begin
            r = mk(0, int'(clamp24(tgx)), int'(clamp24(tgy)), int'(clamp24(tgz)),
                   $urandom_range(300, 12000));
            send_request(r, 0, none);
            n++;
          end
        end
      end
    end
    drain();
    $display("Sent %0d requests over six register settings; %0d results, %0d arrivals.",
             sent, res_cnt, arr_cnt);
    if (errors == 0 && pending_pos.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
